// ===== rtl/mbps_pkg.sv =====
package mbps_pkg;

   localparam int MAX_LEN_DEF     = 8;
   localparam int OFFSET_BITS_DEF = 32;

   localparam int DATA_BITS    = 8;
   localparam int OUT_OFF_BITS = 32;
   localparam int PAT_BITS     = 64;
   localparam int MASK_BITS    = 8;
   localparam int LEN_BITS     = 4;

   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 64;

   localparam logic [CSR_IDX_BITS-1:0] CSR_PATTERN = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MASK    = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LENGTH  = 2'd2;

   typedef struct packed {
      logic [PAT_BITS-1:0]  pattern;
      logic [MASK_BITS-1:0] mask;
      logic [LEN_BITS-1:0]  length;
   } cfg_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } win_ctl_type;

   typedef struct packed {
      logic                    found;
      logic [OUT_OFF_BITS-1:0] match_offset;
   } rsp_type;

   // byte of the given age against the pattern position it lines up with
   function automatic logic pos_hit(logic [DATA_BITS-1:0] d, cfg_type cfg,
                                    logic [LEN_BITS-1:0] age);
      logic [LEN_BITS-1:0] diff;
      logic [2:0]          idx;
      diff = cfg.length - age - 4'd1;
      idx  = diff[2:0];
      if (cfg.length <= age) begin
         return 1'b1;
      end
      return cfg.mask[idx] | (d == cfg.pattern[{idx, 3'b000} +: DATA_BITS]);
   endfunction

endpackage

// ===== rtl/mbps_if.sv =====
interface mbps_req_if;
   import mbps_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [DATA_BITS-1:0] data_byte;
   logic                 last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mbps_rsp_if;
   import mbps_pkg::*;
   logic                    valid;
   logic                    ready;
   logic                    found;
   logic [OUT_OFF_BITS-1:0] match_offset;

   modport source (output valid, output found, output match_offset, input ready);
   modport sink   (input valid, input found, input match_offset, output ready);
endinterface

// ===== rtl/masked_byte_pattern_scan.sv =====
// Masked byte pattern scan.
// req_chan takes one byte of a memory region per item, last_byte marking
// the final byte. rsp_chan gives at most one item per region: found = 1 with
// the offset of the first byte of the first match, or found = 0 with offset
// 0 at the last byte when nothing matched. Bytes after a match give nothing.
// Registers go in through csr_we/csr_index/csr_wdata: index 0 pattern bytes,
// 1 wildcard mask, 2 pattern length; the user must write them only between
// regions (not enforced by the block). Throughput: one byte per cycle while
// req_chan.ready is high. The window is a row of MAX_LEN-1 shift cells, each
// comparing its byte in parallel; the full compare and offset subtract sit
// in the accepting cycle, and the result is registered before rsp_chan.
// Reset clears registers, window, byte counter and pending results.
// A stalled receiver is covered by an output register plus a skid entry:
// bytes keep flowing until both hold a result, then req_chan.ready drops
// until rsp_chan.ready returns.
module masked_byte_pattern_scan #(
   parameter int MAX_LEN     = mbps_pkg::MAX_LEN_DEF,
   parameter int OFFSET_BITS = mbps_pkg::OFFSET_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   mbps_req_if.sink                           req_chan,
   mbps_rsp_if.source                         rsp_chan,
   input  logic                               csr_we,
   input  logic [mbps_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [mbps_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import mbps_pkg::*;

   cfg_type                cfg_ff;
   logic [OFFSET_BITS-1:0] count_ff, count_in;
   logic                   done_ff, done_in;

   logic [DATA_BITS-1:0]   win [MAX_LEN];
   logic [MAX_LEN-1:0]     hits;
   win_ctl_type            ctl;

   logic                   accept;
   logic                   len_ok;
   logic                   count_sat;
   logic                   count_ok;
   logic                   match;
   logic [LEN_BITS-1:0]    len_m1;
   logic [OFFSET_BITS-1:0] len_m1_ext;
   logic [OFFSET_BITS-1:0] off;
   logic [63:0]            off_wide;
   logic                   push;
   rsp_type                push_data;
   logic                   buf_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PATTERN: cfg_ff.pattern <= csr_wdata[PAT_BITS-1:0];
            CSR_MASK:    cfg_ff.mask    <= csr_wdata[MASK_BITS-1:0];
            CSR_LENGTH:  cfg_ff.length  <= csr_wdata[LEN_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign accept         = req_chan.valid && req_chan.ready;
   assign req_chan.ready = buf_ready;

   assign ctl.shift = accept && !done_ff;
   assign ctl.clear = accept && req_chan.last_byte;

   assign win[0]  = req_chan.data_byte;
   assign hits[0] = pos_hit(req_chan.data_byte, cfg_ff, '0);

   for (genvar k = 1; k < MAX_LEN; k++) begin : g_cell
      mbps_cell #(.AGE(k)) u_cell (
         .clock  (clock),
         .reset  (reset),
         .ctl    (ctl),
         .cfg    (cfg_ff),
         .d_prev (win[k-1]),
         .d_out  (win[k]),
         .hit    (hits[k])
      );
   end

   assign len_ok     = (cfg_ff.length != '0) && (cfg_ff.length <= LEN_BITS'(MAX_LEN));
   assign len_m1     = cfg_ff.length - 4'd1;
   assign len_m1_ext = {{(OFFSET_BITS-LEN_BITS){1'b0}}, len_m1};
   assign count_sat  = &count_ff;
   assign count_ok   = count_sat || (count_ff >= len_m1_ext);
   assign match      = len_ok && count_ok && (&hits);

   assign off      = count_sat ? count_ff : (count_ff - len_m1_ext);
   assign off_wide = 64'(off);

   assign push = accept && !done_ff && (match || req_chan.last_byte);
   always_comb begin
      push_data.found        = match;
      push_data.match_offset = '0;
      if (match) begin
         push_data.match_offset = (|off_wide[63:32]) ? '1 : off_wide[31:0];
      end
   end

   always_comb begin
      count_in = count_ff;
      done_in  = done_ff;
      if (accept) begin
         if (req_chan.last_byte) begin
            count_in = '0;
            done_in  = 1'b0;
         end else if (!done_ff) begin
            if (!count_sat) begin
               count_in = count_ff + 1'b1;
            end
            done_in = match;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   mbps_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .in_ready  (buf_ready),
      .rsp_chan  (rsp_chan)
   );

   a_match_sets_done: assert property (@(posedge clock) disable iff (reset)
      (accept && !done_ff && match && !req_chan.last_byte) |=> done_ff)
      else $error("match did not close the region");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.last_byte) |=> (count_ff == '0) && !done_ff)
      else $error("region state not cleared after last item");

   a_no_push_after_done: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !push)
      else $error("result after region already matched");

   a_notfound_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.found) |-> (rsp_chan.match_offset == '0))
      else $error("not-found item with nonzero offset");

endmodule

// ===== rtl/mbps_cell.sv =====
module mbps_cell #(
   parameter int AGE = 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  mbps_pkg::win_ctl_type          ctl,
   input  mbps_pkg::cfg_type              cfg,
   input  logic [mbps_pkg::DATA_BITS-1:0] d_prev,
   output logic [mbps_pkg::DATA_BITS-1:0] d_out,
   output logic                           hit
);
   import mbps_pkg::*;

   logic [DATA_BITS-1:0] d_ff;
   logic [DATA_BITS-1:0] d_in;

   always_comb begin
      d_in = d_ff;
      if (ctl.clear) begin
         d_in = '0;
      end else if (ctl.shift) begin
         d_in = d_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_ff <= '0;
      end else begin
         d_ff <= d_in;
      end
   end

   assign d_out = d_ff;
   assign hit   = pos_hit(d_ff, cfg, LEN_BITS'(AGE));

endmodule

// ===== rtl/mbps_rsp_buf.sv =====
module mbps_rsp_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mbps_pkg::rsp_type push_data,
   output logic              in_ready,
   mbps_rsp_if.source        rsp_chan
);
   import mbps_pkg::*;

   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_ff, out_in;
   rsp_type skid_ff, skid_in;
   logic    pop;

   assign pop      = out_valid_ff && rsp_chan.ready;
   assign in_ready = !skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_in       = push_data;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.found        = out_ff.found;
   assign rsp_chan.match_offset = out_ff.match_offset;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds an item while output is empty");

endmodule

// ===== bench/masked_byte_pattern_scan_tb.sv =====
module masked_byte_pattern_scan_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mbps_pkg::*;

   localparam int QUIET_LIMIT = 500;
   localparam int ITEM_TARGET = 1050;
   localparam int TAIL_ITEMS  = 150;
   localparam int WIN_DEPTH   = MAX_LEN_DEF - 1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_UNUSED = 2'd3;

   typedef enum bit {ROW_BYTE, ROW_REG} row_kind_type;

   typedef struct packed {
      row_kind_type             kind;
      logic [CSR_IDX_BITS-1:0]  idx;
      logic [CSR_DATA_BITS-1:0] wdata;
      logic [DATA_BITS-1:0]     data;
      logic                     last;
      logic                     typed;
      logic                     found;
      logic [OUT_OFF_BITS-1:0]  offset;
   } row_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   mbps_req_if req_chan ();
   mbps_rsp_if rsp_chan ();

   masked_byte_pattern_scan uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // typed expectation travelling with the item being offered
   logic                    row_typed;
   logic                    row_found;
   logic [OUT_OFF_BITS-1:0] row_offset;

   int send_gap_pct   = 20;
   int recv_stall_pct = 20;
   int items_sent     = 0;
   int errors         = 0;
   int quiet_cycles   = 0;

   // predictor state
   logic [PAT_BITS-1:0]        pat_copy;
   logic [MASK_BITS-1:0]       wild_copy;
   logic [LEN_BITS-1:0]        len_copy;
   logic [DATA_BITS-1:0]       prev_bytes [0:WIN_DEPTH-1];
   logic [OFFSET_BITS_DEF-1:0] bytes_seen;
   bit                         hit_reported;

   rsp_type awaited_outcomes [$];

   function automatic row_type set_reg(logic [CSR_IDX_BITS-1:0] idx,
                                       logic [CSR_DATA_BITS-1:0] v);
      row_type r;
      r = '0;
      r.kind  = ROW_REG;
      r.idx   = idx;
      r.wdata = v;
      return r;
   endfunction

   function automatic row_type feed(logic [DATA_BITS-1:0] d, logic l);
      row_type r;
      r = '0;
      r.kind = ROW_BYTE;
      r.data = d;
      r.last = l;
      return r;
   endfunction

   function automatic row_type feed_expect(logic [DATA_BITS-1:0] d, logic l, logic f,
                                           logic [OUT_OFF_BITS-1:0] off);
      row_type r;
      r = feed(d, l);
      r.typed  = 1'b1;
      r.found  = f;
      r.offset = off;
      return r;
   endfunction

   task automatic clear_region();
      for (int k = 0; k < WIN_DEPTH; k++) begin
         prev_bytes[k] = '0;
      end
      bytes_seen   = '0;
      hit_reported = 1'b0;
   endtask

   task automatic apply_reg_write(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] v);
      case (idx)
         CSR_PATTERN: begin
            pat_copy = v;
         end
         CSR_MASK: begin
            wild_copy = v[MASK_BITS-1:0];
         end
         CSR_LENGTH: begin
            len_copy = v[LEN_BITS-1:0];
         end
         default: begin
         end
      endcase
   endtask

   task automatic scan_byte(input logic [DATA_BITS-1:0] d, input logic l,
                            output bit has, output rsp_type res);
      logic [DATA_BITS-1:0] ages [0:MAX_LEN_DEF-1];
      int ln;
      int k;
      bit hit;
      has = 1'b0;
      res = '0;
      if (!hit_reported) begin
         ages[0] = d;
         for (k = 1; k < MAX_LEN_DEF; k++) begin
            ages[k] = prev_bytes[k-1];
         end
         ln  = int'(len_copy);
         hit = ln != 0 && ln <= MAX_LEN_DEF;
         if (hit && bytes_seen != '1 && bytes_seen < OFFSET_BITS_DEF'(ln - 1)) begin
            hit = 1'b0;
         end
         if (hit) begin
            for (k = 0; k < ln; k++) begin
               if (!wild_copy[k] && ages[ln-1-k] != pat_copy[8*k +: 8]) begin
                  hit = 1'b0;
               end
            end
         end
         if (hit) begin
            has   = 1'b1;
            res.found = 1'b1;
            res.match_offset = (bytes_seen == '1) ? bytes_seen
                                                  : bytes_seen - OFFSET_BITS_DEF'(ln - 1);
            hit_reported = 1'b1;
         end else if (l) begin
            has = 1'b1;
         end
         for (k = WIN_DEPTH - 1; k > 0; k--) begin
            prev_bytes[k] = prev_bytes[k-1];
         end
         prev_bytes[0] = d;
         if (bytes_seen != '1) begin
            bytes_seen++;
         end
      end
      if (l) begin
         clear_region();
      end
   endtask

   // predictor and checker
   always @(posedge clock) begin
      bit      has;
      rsp_type res;
      rsp_type want;
      if (reset) begin
         pat_copy  = '0;
         wild_copy = '0;
         len_copy  = '0;
         clear_region();
      end else begin
         if (csr_we) begin
            apply_reg_write(csr_index, csr_wdata);
         end
         if (req_chan.valid && req_chan.ready) begin
            scan_byte(req_chan.data_byte, req_chan.last_byte, has, res);
            if (row_typed) begin
               want.found        = row_found;
               want.match_offset = row_offset;
               awaited_outcomes.push_back(want);
            end else if (has) begin
               awaited_outcomes.push_back(res);
            end
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (awaited_outcomes.size() == 0) begin
               $display("%0t: unexpected item: found %0b offset %0d", $time,
                        rsp_chan.found, rsp_chan.match_offset);
               errors++;
            end else begin
               want = awaited_outcomes.pop_front();
               if (rsp_chan.found !== want.found) begin
                  $display("%0t: found mismatch: expected %0b actual %0b", $time,
                           want.found, rsp_chan.found);
                  errors++;
               end
               if (rsp_chan.match_offset !== want.match_offset) begin
                  $display("%0t: match_offset mismatch: expected %0d actual %0d", $time,
                           want.match_offset, rsp_chan.match_offset);
                  errors++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || csr_we || (req_chan.valid && req_chan.ready)
          || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   // receiver with stall bursts
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (recv_stall_pct != 0 && $urandom_range(0, 99) < recv_stall_pct) begin
            stall_left = $urandom_range(1, 6) - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   task automatic push_byte(logic [DATA_BITS-1:0] d, logic l, logic typed, logic f,
                            logic [OUT_OFF_BITS-1:0] off);
      csr_we <= 1'b0;
      if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.data_byte <= d;
      req_chan.last_byte <= l;
      row_typed          <= typed;
      row_found          <= f;
      row_offset         <= off;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
   endtask

   // hold off until every result is in and the pipeline has emptied
   task automatic settle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (awaited_outcomes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic random_region(logic [PAT_BITS-1:0] pat, logic [MASK_BITS-1:0] msk, int ln);
      logic [DATA_BITS-1:0] body [$];
      logic [DATA_BITS-1:0] b;
      int  size;
      int  at;
      int  k;
      bit  plant;
      plant = ln != 0 && $urandom_range(0, 9) < 7;
      size  = $urandom_range(1, ($urandom_range(0, 9) == 0) ? 40 : 16);
      if (plant && size < ln) begin
         size = ln + $urandom_range(0, 4);
      end
      for (k = 0; k < size; k++) begin
         if (ln != 0 && $urandom_range(0, 1) == 1) begin
            b = pat[8*$urandom_range(0, ln - 1) +: 8];
         end else begin
            b = DATA_BITS'($urandom);
         end
         body.push_back(b);
      end
      if (plant) begin
         at = $urandom_range(0, size - ln);
         for (k = 0; k < ln; k++) begin
            body[at+k] = msk[k] ? DATA_BITS'($urandom) : pat[8*k +: 8];
         end
         if ($urandom_range(0, 5) == 0) begin
            k = at + $urandom_range(0, ln - 1);
            body[k] = body[k] ^ DATA_BITS'(1 << $urandom_range(0, 7));
         end
      end
      for (k = 0; k < size; k++) begin
         push_byte(body[k], k == size - 1, 1'b0, 1'b0, '0);
      end
   endtask

   initial begin
      row_type                  script [0:36];
      logic [CSR_DATA_BITS-1:0] hi;
      logic [PAT_BITS-1:0]      pat;
      logic [MASK_BITS-1:0]     msk;
      logic [LEN_BITS-1:0]      len;
      bit                       prev_reg;
      int                       sel;

      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      req_chan.valid     = 1'b0;
      req_chan.data_byte = '0;
      req_chan.last_byte = 1'b0;
      row_typed          = 1'b0;
      row_found          = 1'b0;
      row_offset         = '0;

      script = '{
         feed_expect(8'h00, 1'b1, 1'b0, 0),          // length 0 after reset
         set_reg(CSR_PATTERN, 64'h0000_0000_0000_FF00),
         set_reg(CSR_LENGTH, 64'd2),
         feed(8'hFF, 1'b0),                          // zero window must not pair up
         feed(8'h00, 1'b0),
         feed_expect(8'hFF, 1'b0, 1'b1, 1),
         feed(8'h00, 1'b0),                          // ignored after the hit
         feed(8'hFF, 1'b1),
         feed(8'h00, 1'b0),
         feed_expect(8'hFF, 1'b1, 1'b1, 0),          // hit on the last byte
         set_reg(CSR_PATTERN, 64'hFF00_0000_0000_00FF),
         set_reg(CSR_MASK, 64'h7E),
         set_reg(CSR_LENGTH, 64'd8),
         feed(8'hFF, 1'b0),
         feed(8'h11, 1'b0),
         feed(8'h22, 1'b0),
         feed(8'h33, 1'b0),
         feed(8'h44, 1'b0),
         feed(8'h55, 1'b0),
         feed(8'h66, 1'b0),
         feed_expect(8'hFF, 1'b1, 1'b1, 0),
         set_reg(CSR_MASK, 64'hFFFF_FFFF_FFFF_FFFF),
         set_reg(CSR_LENGTH, 64'hFFFF_FFFF_FFFF_FFF9), // longer than the window
         feed(8'h00, 1'b0),
         feed_expect(8'h01, 1'b1, 1'b0, 0),
         set_reg(CSR_PATTERN, 64'hFFFF_FFFF_FFFF_FF5A),
         set_reg(CSR_MASK, 64'hFE),                   // wildcards beyond length
         set_reg(CSR_LENGTH, 64'd1),
         feed(8'h5B, 1'b0),
         feed_expect(8'h5A, 1'b1, 1'b1, 1),
         set_reg(CSR_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF),
         set_reg(CSR_LENGTH, 64'd0),
         set_reg(CSR_PATTERN, 64'h0000_0000_0000_3377),
         set_reg(CSR_MASK, 64'h0),
         feed(8'h77, 1'b0),
         set_reg(CSR_LENGTH, 64'd2),                  // change within a region
         feed_expect(8'h33, 1'b1, 1'b1, 0)
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      prev_reg = 1'b0;
      foreach (script[i]) begin
         if (script[i].kind == ROW_REG) begin
            if (!prev_reg) begin
               settle();
            end
            write_reg(script[i].idx, script[i].wdata);
            prev_reg = 1'b1;
         end else begin
            push_byte(script[i].data, script[i].last, script[i].typed, script[i].found,
                      script[i].offset);
            prev_reg = 1'b0;
         end
      end

      while (items_sent < ITEM_TARGET) begin
         settle();
         hi  = {$urandom, $urandom};
         sel = $urandom_range(0, 9);
         if (sel == 0) begin
            pat = '1;
         end else if (sel == 1) begin
            pat = '0;
         end else if (sel < 4) begin
            for (int k = 0; k < 8; k++) begin
               pat[8*k +: 8] = $urandom_range(0, 1) ? 8'hAA : 8'h55;
            end
         end else begin
            pat = {$urandom, $urandom};
         end
         msk = ($urandom_range(0, 1) == 1) ? MASK_BITS'($urandom) : '0;
         sel = $urandom_range(0, 19);
         if (sel < 2) begin
            len = '0;
         end else if (sel < 4) begin
            len = LEN_BITS'($urandom_range(9, 15));
         end else if (sel < 7) begin
            len = LEN_BITS'(MAX_LEN_DEF);
         end else if (sel < 9) begin
            len = 4'd1;
         end else begin
            len = LEN_BITS'($urandom_range(2, 7));
         end
         write_reg(CSR_PATTERN, pat);
         write_reg(CSR_MASK, {hi[CSR_DATA_BITS-1:MASK_BITS], msk});
         write_reg(CSR_LENGTH, {hi[CSR_DATA_BITS-1:LEN_BITS], len});
         if ($urandom_range(0, 7) == 0) begin
            write_reg(CSR_UNUSED, hi);
         end
         if (items_sent >= ITEM_TARGET - TAIL_ITEMS) begin
            send_gap_pct   = 0;
            recv_stall_pct = 0;
         end else begin
            sel = $urandom_range(0, 2);
            send_gap_pct   = (sel == 0) ? 0 : (sel == 1) ? 15 : 40;
            sel = $urandom_range(0, 2);
            recv_stall_pct = (sel == 0) ? 0 : (sel == 1) ? 15 : 40;
         end
         repeat ($urandom_range(1, 6)) begin
            random_region(pat, msk, (len > MAX_LEN_DEF) ? MAX_LEN_DEF : int'(len));
         end
      end

      settle();
      repeat (10) @(posedge clock);
      if (errors == 0 && awaited_outcomes.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
